@@ sv/tmcl_command_frame_link_defines.svh @@
// Assertion macros shared by the link's modules.
// Define NO_ASSERTIONS to compile them away.
`ifndef TMCL_COMMAND_FRAME_LINK_DEFINES_SVH
`define TMCL_COMMAND_FRAME_LINK_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising edge outside reset.
`define TMCL_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Checked at every rising edge, during reset as well.
`define TMCL_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`else

`define TMCL_ASSERT(label, clk, rstn, prop)
`define TMCL_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

@@ sv/tmcl_pkg.sv @@
package tmcl_pkg;

  // Frame geometry.
  localparam int unsigned FrameLen = 9;
  localparam int unsigned IdxW     = 4;
  localparam logic [IdxW-1:0] LAST_IDX = 4'd8;

  // Reply byte positions of interest.
  localparam logic [IdxW-1:0] RX_POS_STATUS = 4'd2;
  localparam logic [IdxW-1:0] RX_POS_REPORT = 4'd3;
  localparam logic [IdxW-1:0] RX_POS_VALUE  = 4'd7;

  // Highest status code that counts as an error.
  localparam logic [7:0] MAX_ERR_STATUS = 8'd6;

  // Result kinds.
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_VALUE  = 2'd2;

  // Request kinds.
  localparam logic REQ_COMMAND = 1'b0;
  localparam logic REQ_REPLY   = 1'b1;

  // One queued item: a complete command frame, or a reply byte in frame[0].
  typedef struct packed {
    logic                           is_reply;
    logic [FrameLen-1:0][7:0]       frame;
  } queue_entry_t;

endpackage

@@ sv/tmcl_req_if.sv @@
interface tmcl_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [7:0]         cmd_number;
  logic [7:0]         command_type;
  logic [7:0]         motor_or_bank;
  logic signed [31:0] command_value;
  logic [7:0]         rx_byte;

  modport source (
    output valid, req_type, cmd_number, command_type, motor_or_bank,
           command_value, rx_byte,
    input  ready
  );

  modport sink (
    input  valid, req_type, cmd_number, command_type, motor_or_bank,
           command_value, rx_byte,
    output ready
  );
endinterface

@@ sv/tmcl_res_if.sv @@
interface tmcl_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic [7:0]         tx_byte;
  logic               last_of_run;
  logic [7:0]         status_code;
  logic               status_is_error;
  logic [7:0]         reply_command;
  logic signed [31:0] reply_value;

  modport source (
    output valid, result_kind, tx_byte, last_of_run, status_code,
           status_is_error, reply_command, reply_value,
    input  ready
  );

  modport sink (
    input  valid, result_kind, tx_byte, last_of_run, status_code,
           status_is_error, reply_command, reply_value,
    output ready
  );
endinterface

@@ sv/tmcl_fifo.sv @@
`include "tmcl_command_frame_link_defines.svh"

module tmcl_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  tmcl_pkg::queue_entry_t push_data_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   head_valid_o,
  output tmcl_pkg::queue_entry_t head_o
);
  import tmcl_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  queue_entry_t          entries_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o       = (count_q == CntFull);
  assign head_valid_o = (count_q != '0);
  assign head_o       = entries_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  `TMCL_ASSERT(a_fifo_count_bound, clk_i, rst_ni, count_q <= CntFull)

endmodule

@@ sv/tmcl_front.sv @@
module tmcl_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             module_address_i,
  tmcl_req_if.sink               req,
  output logic                   push_o,
  output tmcl_pkg::queue_entry_t push_data_o,
  input  logic                   full_i
);
  import tmcl_pkg::*;

  logic         valid_q;
  queue_entry_t entry_q, entry_d;
  logic         accept;
  logic [7:0]   checksum;

  // The stage refills in the cycle it empties into the queue.
  assign req.ready   = !valid_q || !full_i;
  assign accept      = req.valid && req.ready;
  assign push_o      = valid_q;
  assign push_data_o = entry_q;

  always_comb begin
    entry_d.is_reply = (req.req_type == REQ_REPLY);
    entry_d.frame    = '0;
    if (req.req_type == REQ_REPLY) begin
      entry_d.frame[0] = req.rx_byte;
    end else begin
      entry_d.frame[0] = module_address_i;
      entry_d.frame[1] = req.cmd_number;
      entry_d.frame[2] = req.command_type;
      entry_d.frame[3] = req.motor_or_bank;
      entry_d.frame[4] = req.command_value[31:24];
      entry_d.frame[5] = req.command_value[23:16];
      entry_d.frame[6] = req.command_value[15:8];
      entry_d.frame[7] = req.command_value[7:0];
    end
    // Additive checksum, modulo 256, of the eight leading bytes.
    checksum = entry_d.frame[0] + entry_d.frame[1] + entry_d.frame[2] + entry_d.frame[3]
             + entry_d.frame[4] + entry_d.frame[5] + entry_d.frame[6] + entry_d.frame[7];
    if (req.req_type != REQ_REPLY) begin
      entry_d.frame[8] = checksum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req.ready) begin
      valid_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
    end
  end

endmodule

@@ sv/tmcl_back.sv @@
`include "tmcl_command_frame_link_defines.svh"

module tmcl_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   head_valid_i,
  input  tmcl_pkg::queue_entry_t head_i,
  output logic                   pop_o,
  tmcl_res_if.source             res
);
  import tmcl_pkg::*;

  logic [IdxW-1:0] tx_idx_q, tx_idx_d;
  logic [IdxW-1:0] rx_pos_q, rx_pos_d;
  logic [31:0]     rx_shift_q, rx_shift_d;
  logic [7:0]      rx_status_q, rx_status_d;
  logic [7:0]      rx_cmd_q;
  logic            rx_cmd_we;

  logic            out_valid_q, out_valid_d;
  logic            out_load;
  logic [1:0]      kind_d;
  logic [7:0]      tx_byte_d;
  logic            last_d;
  logic [7:0]      status_d;
  logic            err_d;
  logic [7:0]      cmd_d;
  logic [31:0]     value_d;

  logic            slot_free;
  logic            step;
  logic [7:0]      rx_b;
  logic            status_step;
  logic            status_out;

  assign slot_free = !out_valid_q || res.ready;
  assign step      = head_valid_i && slot_free;
  assign rx_b      = head_i.frame[0];

  always_comb begin
    tx_idx_d    = tx_idx_q;
    rx_pos_d    = rx_pos_q;
    rx_shift_d  = rx_shift_q;
    rx_status_d = rx_status_q;
    rx_cmd_we   = 1'b0;
    pop_o       = 1'b0;
    out_load    = 1'b0;
    kind_d      = KIND_TX;
    tx_byte_d   = '0;
    last_d      = 1'b0;
    status_d    = '0;
    err_d       = 1'b0;
    cmd_d       = '0;
    value_d     = '0;
    if (step) begin
      if (!head_i.is_reply) begin
        out_load  = 1'b1;
        tx_byte_d = head_i.frame[tx_idx_q];
        last_d    = (tx_idx_q == LAST_IDX);
        if (tx_idx_q == LAST_IDX) begin
          pop_o    = 1'b1;
          tx_idx_d = '0;
        end else begin
          tx_idx_d = tx_idx_q + 1'b1;
        end
      end else begin
        pop_o      = 1'b1;
        rx_shift_d = {rx_shift_q[23:0], rx_b};
        unique case (rx_pos_q)
          RX_POS_STATUS: begin
            rx_status_d = rx_b;
          end
          RX_POS_REPORT: begin
            rx_shift_d = '0;
            rx_cmd_we  = 1'b1;
            out_load   = 1'b1;
            kind_d     = KIND_STATUS;
            last_d     = 1'b1;
            status_d   = rx_status_q;
            err_d      = (rx_status_q != '0) && (rx_status_q <= MAX_ERR_STATUS);
            cmd_d      = rx_b;
          end
          RX_POS_VALUE: begin
            out_load = 1'b1;
            kind_d   = KIND_VALUE;
            last_d   = 1'b1;
            cmd_d    = rx_cmd_q;
            value_d  = {rx_shift_q[23:0], rx_b};
          end
          default: begin
          end
        endcase
        rx_pos_d = (rx_pos_q == LAST_IDX) ? '0 : rx_pos_q + 1'b1;
      end
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_idx_q    <= '0;
      rx_pos_q    <= '0;
      rx_shift_q  <= '0;
      rx_status_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tx_idx_q    <= tx_idx_d;
      rx_pos_q    <= rx_pos_d;
      rx_shift_q  <= rx_shift_d;
      rx_status_q <= rx_status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_cmd_we) begin
      rx_cmd_q <= rx_b;
    end
    if (out_load) begin
      res.result_kind     <= kind_d;
      res.tx_byte         <= tx_byte_d;
      res.last_of_run     <= last_d;
      res.status_code     <= status_d;
      res.status_is_error <= err_d;
      res.reply_command   <= cmd_d;
      res.reply_value     <= value_d;
    end
  end

  assign res.valid = out_valid_q;

  // Reply byte 3 taken this cycle, and a status report on the output.
  assign status_step = step && head_i.is_reply && (rx_pos_q == RX_POS_REPORT);
  assign status_out  = res.valid && (res.result_kind == KIND_STATUS);

  `TMCL_ASSERT(a_tx_idx_range, clk_i, rst_ni, tx_idx_q <= LAST_IDX)
  `TMCL_ASSERT(a_rx_pos_range, clk_i, rst_ni, rx_pos_q <= LAST_IDX)
  `TMCL_ASSERT(a_status_after_byte3, clk_i, rst_ni, status_step |=> status_out)

endmodule

@@ sv/tmcl_command_frame_link.sv @@
// Host side of a 9-byte binary motor-controller command link.
// Channel req_i (valid/ready) takes two kinds of request. A command
// (req_type 0) becomes nine transmit transfers on res_o: module address,
// command, type, motor or bank, four value bytes most significant first,
// and an additive checksum, the last one flagged by last_of_run. A reply
// byte (req_type 1) advances a frame position; byte 3 yields a status
// report and byte 7 a value report, other bytes give no transfer.
// The module address is written through cfg_we_i/cfg_wdata_i while idle.
// A request passes the front stage register and the queue, and the first
// result is presented on res_o from the back end's output register.
// Throughput: one byte per cycle, set by the back end, which serialises
// frames and stalls while res_o holds a transfer that is not yet taken.
// A queue of Depth items lets requests keep arriving while a frame goes out.
// Reset clears the queue, the frame position and the output stage, and sets
// the module address to 1. When the receiver holds res_o ready low, the
// output holds its transfer, the queue fills, and then req_i ready falls.
module tmcl_command_frame_link #(
  parameter int unsigned Depth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  tmcl_req_if.sink   req_i,
  tmcl_res_if.source res_o
);
  import tmcl_pkg::*;

  // Module address register; to be changed only while no transfer is in flight (the user's duty, not enforced here).
  logic [7:0]   module_address_q;

  logic         push;
  queue_entry_t push_data;
  logic         full;
  logic         pop;
  logic         head_valid;
  queue_entry_t head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      module_address_q <= 8'd1;
    end else if (cfg_we_i) begin
      module_address_q <= cfg_wdata_i;
    end
  end

  // Front: takes requests and builds complete command frames, checksum included, or reply entries.
  tmcl_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .module_address_i (module_address_q),
    .req              (req_i),
    .push_o           (push),
    .push_data_o      (push_data),
    .full_i           (full)
  );

  // Queue between classification and execution.
  tmcl_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Back: serialises frames and tracks the reply frame.
  tmcl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .res          (res_o)
  );

endmodule
